@@ rtl/core/blesd_pkg.sv @@
// Package for the session controller and control decoder.
// Holds phase, command, event and register codes, reset values and packet decode functions.
// No dependencies.
package blesd_pkg;

  localparam int TimeW = 48;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WAIT   = 2'd1,
    PH_STREAM = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_VR_MODE   = 3'd1,
    CMD_SENSOR    = 3'd2,
    CMD_KEEPALIVE = 3'd3,
    CMD_OFF       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ACK_WAIT     = 2'd0,
    REG_KEEPALIVE    = 2'd1,
    REG_SILENCE      = 2'd2,
    REG_MAX_RESTARTS = 2'd3
  } reg_e;

  // event codes; higher codes are ignored notifications
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_CLOSE  = 3'd2;
  localparam logic [2:0] MODE_ECHO   = 3'd3;
  localparam logic [2:0] MODE_PACKET = 3'd4;

  localparam logic [15:0] ACK_WAIT_RST     = 16'd4000;
  localparam logic [15:0] KEEPALIVE_RST    = 16'd10000;
  localparam logic [15:0] SILENCE_RST      = 16'd3000;
  localparam logic [3:0]  MAX_RESTARTS_RST = 4'd2;

  localparam logic [7:0] ECHO_VR_FIRST  = 8'h08;
  localparam logic [7:0] ECHO_VR_SECOND = 8'h00;
  localparam logic [3:0] TOUCH_DOWN     = 4'h1;
  localparam logic [9:0] POS_MAX        = 10'd320;
  localparam logic [6:0] BATT_MAX       = 7'd100;
  localparam logic signed [10:0] AXIS_CENTER = 11'sd160;
  localparam logic signed [15:0] AXIS_SAT    = 16'sh7FFF;
  // ceil(2^18 / 5), exact for quotients of values below 2^18
  localparam logic [15:0] RECIP_5 = 16'd52429;

  function automatic logic [8:0] clamp_pos(input logic [9:0] v);
    logic [8:0] r;
    r = (v > POS_MAX) ? POS_MAX[8:0] : v[8:0];
    return r;
  endfunction

  // (v-160)*32767/160 truncated toward zero, saturated at the top
  function automatic logic signed [15:0] touch_axis(input logic [9:0] v);
    logic signed [10:0] d;
    logic [10:0]        dneg;
    logic [7:0]         mag;
    logic [22:0]        scaled;
    logic [17:0]        m;
    logic [33:0]        prod;
    logic [15:0]        q;
    logic signed [15:0] r;
    d      = signed'({1'b0, v}) - AXIS_CENTER;
    dneg   = 11'(-d);
    mag    = d[10] ? dneg[7:0] : d[7:0];
    scaled = {mag, 15'd0} - 23'(mag);
    m      = scaled[22:5];
    prod   = 34'(m) * 34'(RECIP_5);
    q      = prod[33:18];
    if (d > AXIS_CENTER) begin
      r = AXIS_SAT;
    end else if (d[10]) begin
      r = -signed'(q);
    end else begin
      r = signed'(q);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ble_controller_session_decoder.sv @@
// Session controller and control decoder: phase and deadline logic, packet field decode.
// Depends on blesd_pkg.
// An accepted event passes through the input register and then the result register.
// Throughput: one event per cycle; both stages advance whenever the result register is free
// or being drained. Reset clears the phase, deadlines, counters, flags and both stage valids,
// and loads the configuration registers with their default values.
module ble_controller_session_decoder
  import blesd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          mode_i,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic [7:0]          echo_first_i,
  input  logic [7:0]          echo_second_i,
  input  logic [7:0]          touch_status_byte_i,
  input  logic [7:0]          touch_mid_byte_i,
  input  logic [7:0]          touch_low_byte_i,
  input  logic [7:0]          button_byte_i,
  input  logic [7:0]          battery_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          command_o,
  output logic                release_controls_o,
  output logic                link_failed_o,
  output logic                link_ready_o,
  output logic                controls_valid_o,
  output logic                finger_down_o,
  output logic [8:0]          touch_x_pos_o,
  output logic [8:0]          touch_y_pos_o,
  output logic signed [15:0]  axis_x_o,
  output logic signed [15:0]  axis_y_o,
  output logic [5:0]          buttons_o,
  output logic [6:0]          battery_pct_o
);

  // configuration
  logic [15:0] ack_wait_q, keepalive_q, silence_q;
  logic [3:0]  max_restarts_q;
  logic        cfg_wr;
  reg_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_wait_q     <= ACK_WAIT_RST;
      keepalive_q    <= KEEPALIVE_RST;
      silence_q      <= SILENCE_RST;
      max_restarts_q <= MAX_RESTARTS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACK_WAIT:     ack_wait_q     <= pwdata[15:0];
        REG_KEEPALIVE:    keepalive_q    <= pwdata[15:0];
        REG_SILENCE:      silence_q      <= pwdata[15:0];
        REG_MAX_RESTARTS: max_restarts_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACK_WAIT:     prdata = CfgDataW'(ack_wait_q);
      REG_KEEPALIVE:    prdata = CfgDataW'(keepalive_q);
      REG_SILENCE:      prdata = CfgDataW'(silence_q);
      REG_MAX_RESTARTS: prdata = CfgDataW'(max_restarts_q);
      default:          prdata = '0;
    endcase
  end

  // input register
  logic             in_vld_q;
  logic [2:0]       mode_q;
  logic [TimeW-1:0] now_q;
  logic [7:0]       echo1_q, echo2_q, b54_q, b55_q, b56_q, b58_q, b59_q;
  logic             out_vld_q;
  logic             fire;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q  <= mode_i;
      now_q   <= now_ms_i;
      echo1_q <= echo_first_i;
      echo2_q <= echo_second_i;
      b54_q   <= touch_status_byte_i;
      b55_q   <= touch_mid_byte_i;
      b56_q   <= touch_low_byte_i;
      b58_q   <= button_byte_i;
      b59_q   <= battery_byte_i;
    end
  end

  // session state
  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] next_dl_q, next_dl_d, sil_dl_q, sil_dl_d;
  logic [3:0]       restarts_q, restarts_d;
  logic             ready_q, ready_d, failed_q, failed_d;

  logic [TimeW-1:0] now_ack, now_ka, now_sil, nd_ka;
  logic [9:0]       tx, ty;
  logic             touching;

  assign now_ack  = now_q + TimeW'(ack_wait_q);
  assign now_ka   = now_q + TimeW'(keepalive_q);
  assign now_sil  = now_q + TimeW'(silence_q);
  assign nd_ka    = next_dl_q + TimeW'(keepalive_q);
  assign tx       = {b54_q[3:0], b55_q[7:2]};
  assign ty       = {b55_q[1:0], b56_q};
  assign touching = (b54_q[7:4] == TOUCH_DOWN);

  cmd_e              cmd;
  logic              rel, cv, finger;
  logic [8:0]        xpos, ypos;
  logic signed [15:0] ax, ay;
  logic [5:0]        btn;
  logic [6:0]        batt;

  always_comb begin
    phase_d    = phase_q;
    next_dl_d  = next_dl_q;
    sil_dl_d   = sil_dl_q;
    restarts_d = restarts_q;
    ready_d    = ready_q;
    failed_d   = failed_q;
    cmd        = CMD_NONE;
    rel        = 1'b0;
    cv         = 1'b0;
    finger     = 1'b0;
    xpos       = '0;
    ypos       = '0;
    ax         = '0;
    ay         = '0;
    btn        = '0;
    batt       = '0;
    case (mode_q)
      MODE_TICK: begin
        if (phase_q == PH_WAIT && now_q >= next_dl_q) begin
          cmd       = CMD_SENSOR;
          phase_d   = PH_STREAM;
          next_dl_d = now_ka;
          sil_dl_d  = now_sil;
        end else if (phase_q == PH_STREAM && now_q >= sil_dl_q) begin
          if (restarts_q >= max_restarts_q) begin
            phase_d  = PH_IDLE;
            failed_d = 1'b1;
          end else begin
            restarts_d = restarts_q + 4'd1;
            rel        = 1'b1;
            cmd        = CMD_VR_MODE;
            phase_d    = PH_WAIT;
            next_dl_d  = now_ack;
          end
        end else if (phase_q == PH_STREAM && now_q >= next_dl_q) begin
          cmd       = CMD_KEEPALIVE;
          // catch up when the schedule has fallen behind
          next_dl_d = (nd_ka <= now_q) ? now_ka : nd_ka;
        end
      end
      MODE_START: begin
        cmd       = CMD_VR_MODE;
        phase_d   = PH_WAIT;
        next_dl_d = now_ack;
      end
      MODE_CLOSE: begin
        cmd     = CMD_OFF;
        phase_d = PH_IDLE;
      end
      MODE_ECHO: begin
        if (phase_q == PH_WAIT && echo1_q == ECHO_VR_FIRST && echo2_q == ECHO_VR_SECOND) begin
          cmd       = CMD_SENSOR;
          phase_d   = PH_STREAM;
          next_dl_d = now_ka;
          sil_dl_d  = now_sil;
        end
      end
      MODE_PACKET: begin
        cv = 1'b1;
        if (touching) begin
          finger = 1'b1;
          xpos   = clamp_pos(tx);
          ypos   = clamp_pos(ty);
          ax     = touch_axis(tx);
          ay     = touch_axis(ty);
        end
        btn  = b58_q[5:0];
        batt = (b59_q > 8'(BATT_MAX)) ? BATT_MAX : b59_q[6:0];
        if (phase_q == PH_STREAM) begin
          ready_d    = 1'b1;
          restarts_d = '0;
          sil_dl_d   = now_sil;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      next_dl_q  <= '0;
      sil_dl_q   <= '0;
      restarts_q <= '0;
      ready_q    <= 1'b0;
      failed_q   <= 1'b0;
    end else if (fire) begin
      phase_q    <= phase_d;
      next_dl_q  <= next_dl_d;
      sil_dl_q   <= sil_dl_d;
      restarts_q <= restarts_d;
      ready_q    <= ready_d;
      failed_q   <= failed_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      command_o          <= cmd;
      release_controls_o <= rel;
      link_failed_o      <= failed_d;
      link_ready_o       <= ready_d;
      controls_valid_o   <= cv;
      finger_down_o      <= finger;
      touch_x_pos_o      <= xpos;
      touch_y_pos_o      <= ypos;
      axis_x_o           <= ax;
      axis_y_o           <= ay;
      buttons_o          <= btn;
      battery_pct_o      <= batt;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
